// ===== rtl/modbus_rtu_read_master_top_defines.svh =====
// ---------------------------------------------------------------------------
// Modbus RTU read master: assertion macros
// Clocked property checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef MODBUS_RTU_READ_MASTER_TOP_DEFINES_SVH
`define MODBUS_RTU_READ_MASTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MBRM_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("modbus rtu read master: same-cycle check failed");
`define MBRM_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("modbus rtu read master: next-cycle check failed");
`else
`define MBRM_ASSERT_IMP(label, pre, post)
`define MBRM_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ===== rtl/mbrm_pkg.sv =====
// ---------------------------------------------------------------------------
// Modbus RTU read master: shared package
// Action and status codes, CRC-16 byte step and inter-module structs.
// ---------------------------------------------------------------------------
package mbrm_pkg;

   localparam int          COUNT_W      = 8;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam logic [7:0]  FUNC_READ    = 8'h03;
   localparam logic        KIND_TX      = 1'b0;
   localparam logic        KIND_RESULT  = 1'b1;
   localparam logic [2:0]  TX_CRC_LO_IDX = 3'd6;
   localparam logic [2:0]  TX_LAST_IDX  = 3'd7;
   // reply byte count from which the older trailer byte enters the payload window
   localparam logic [COUNT_W-1:0] PAYLOAD_FIRST = 8'd5;

   typedef enum logic [1:0] {
      ACT_SEND = 2'd0,
      ACT_BYTE = 2'd1,
      ACT_END  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_REPLY = 2'd1,
      ST_CRC_ERR  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic       clear;
      logic       push;
      logic [7:0] rx_byte;
   } reply_ctl_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] value;
   } reply_res_type;

   // one byte through the reflected CRC-16
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/mbrm_reply.sv =====
// ---------------------------------------------------------------------------
// Modbus RTU read master: reply tracker
// Folds reply bytes into the CRC behind a two-byte trailer, keeps the payload
// window and reports the status of the finished reply.
// ---------------------------------------------------------------------------
module mbrm_reply
   import mbrm_pkg::*;
#(
   parameter int MAX_FRAME = 128
) (
   input  logic          clock,
   input  logic          reset,
   input  reply_ctl_type ctl,
   output reply_res_type res
);

   localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_FRAME);

   logic [15:0]        crc_ff,    crc_in;
   logic [COUNT_W-1:0] count_ff,  count_in;
   logic [15:0]        tail_ff,   tail_in;
   logic [31:0]        window_ff, window_in;
   logic               ovf_ff,    ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_INIT;
         count_ff  <= '0;
         tail_ff   <= '0;
         window_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         count_ff  <= count_in;
         tail_ff   <= tail_in;
         window_ff <= window_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_comb begin
      crc_in    = crc_ff;
      count_in  = count_ff;
      tail_in   = tail_ff;
      window_in = window_ff;
      ovf_in    = ovf_ff;
      priority if (ctl.clear) begin
         crc_in    = CRC_INIT;
         count_in  = '0;
         tail_in   = '0;
         window_in = '0;
         ovf_in    = 1'b0;
      end else if (ctl.push) begin
         if (count_ff >= MaxCount) begin
            // drop the beat, remember it
            ovf_in = 1'b1;
         end else begin
            if (count_ff >= COUNT_W'(2)) begin
               crc_in = crc_byte(crc_ff, tail_ff[15:8]);
            end
            if (count_ff >= PAYLOAD_FIRST) begin
               window_in = {window_ff[23:0], tail_ff[15:8]};
            end
            tail_in  = {tail_ff[7:0], ctl.rx_byte};
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      res.value = '0;
      priority if (ovf_ff) begin
         res.status = ST_OVERFLOW;
      end else if (count_ff == '0) begin
         res.status = ST_NO_REPLY;
      end else if (count_ff == COUNT_W'(1)) begin
         res.status = ST_CRC_ERR;
      end else if (crc_ff[7:0] == tail_ff[15:8] && crc_ff[15:8] == tail_ff[7:0]) begin
         res.status = ST_OK;
         res.value  = window_ff;
      end else begin
         res.status = ST_CRC_ERR;
      end
   end

endmodule

// ===== rtl/modbus_rtu_read_master_top.sv =====
// ---------------------------------------------------------------------------
// Modbus RTU read master (function 0x03)
// Sends read-holding-register requests with CRC-16 and checks the replies.
// ---------------------------------------------------------------------------
//  channel | dir | beat contents
//  req     | in  | tuser action; tdata slave_addr, reg_addr, reg_count, rx_byte
//  rsp     | out | tuser kind; tlast last; tdata tx_byte, value, status
//
//  Reply bytes give no result beat; an end beat gives one result beat.
//  A send beat gives eight result beats, one per cycle while rsp_tready is
//  high; the CRC is built one byte per beat as the frame goes out, so req is
//  held off until the eighth byte leaves. The result register decouples the
//  two sides. Reset is synchronous and empties the reply state.
// ---------------------------------------------------------------------------
`include "modbus_rtu_read_master_top_defines.svh"

module modbus_rtu_read_master_top
   import mbrm_pkg::*;
#(
   parameter int MAX_FRAME = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // slave_addr[7:0], reg_addr[23:8], reg_count[39:24],
                                   // rx_byte[47:40]
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // tx_byte[7:0], value[39:8], status[41:40], zero above
   output logic        rsp_tuser,  // kind
   output logic        rsp_tlast
);

   logic [7:0]  slave_addr;
   logic [15:0] reg_addr;
   logic [15:0] reg_count;
   logic [7:0]  rx_byte;
   action_type  action;

   logic accept_in, send_go, byte_go, end_go;
   logic rsp_take, tx_step, tx_done, out_free;

   reply_ctl_type reply_ctl;
   reply_res_type reply_res;

   logic        rsp_valid_ff,  rsp_valid_in;
   logic        rsp_kind_ff,   rsp_kind_in;
   logic [7:0]  rsp_byte_ff,   rsp_byte_in;
   logic        rsp_last_ff,   rsp_last_in;
   logic [31:0] rsp_value_ff,  rsp_value_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic        tx_active_ff, tx_active_in;
   logic [2:0]  tx_idx_ff,    tx_idx_in;
   logic [39:0] tx_shift_ff,  tx_shift_in;
   logic [15:0] tx_crc_ff,    tx_crc_in;
   logic [2:0]  tx_next;

   assign slave_addr = req_tdata[7:0];
   assign reg_addr   = req_tdata[23:8];
   assign reg_count  = req_tdata[39:24];
   assign rx_byte    = req_tdata[47:40];
   assign action     = action_type'(req_tuser);

   assign rsp_take = rsp_valid_ff && rsp_tready;
   assign tx_step  = tx_active_ff && rsp_take && (tx_idx_ff != TX_LAST_IDX);
   assign tx_done  = tx_active_ff && rsp_take && (tx_idx_ff == TX_LAST_IDX);
   assign out_free = (!rsp_valid_ff || rsp_tready) &&
                     (!tx_active_ff || tx_idx_ff == TX_LAST_IDX);
   assign tx_next  = tx_idx_ff + 3'd1;

   assign req_tready = out_free;
   assign accept_in  = req_tvalid && req_tready;

   always_comb begin
      send_go = 1'b0;
      byte_go = 1'b0;
      end_go  = 1'b0;
      unique case (action)
         ACT_SEND: send_go = accept_in;
         ACT_BYTE: byte_go = accept_in;
         ACT_END:  end_go  = accept_in;
         default:  ;
      endcase
   end

   assign reply_ctl.clear   = send_go || end_go;
   assign reply_ctl.push    = byte_go;
   assign reply_ctl.rx_byte = rx_byte;

   mbrm_reply #(
      .MAX_FRAME (MAX_FRAME)
   ) u_reply (
      .clock (clock),
      .reset (reset),
      .ctl   (reply_ctl),
      .res   (reply_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tx_active_ff <= 1'b0;
         tx_idx_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         tx_active_ff <= tx_active_in;
         tx_idx_ff    <= tx_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      tx_shift_ff   <= tx_shift_in;
      tx_crc_ff     <= tx_crc_in;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      tx_active_in  = tx_done ? 1'b0 : tx_active_ff;
      tx_idx_in     = tx_idx_ff;
      tx_shift_in   = tx_shift_ff;
      tx_crc_in     = tx_crc_ff;
      priority if (send_go) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_TX;
         rsp_byte_in   = slave_addr;
         rsp_last_in   = 1'b0;
         rsp_value_in  = '0;
         rsp_status_in = ST_OK;
         tx_active_in  = 1'b1;
         tx_idx_in     = '0;
         // bytes still to go, next one lowest
         tx_shift_in   = {reg_count[7:0], reg_count[15:8], reg_addr[7:0], reg_addr[15:8],
                          FUNC_READ};
         tx_crc_in     = crc_byte(CRC_INIT, slave_addr);
      end else if (end_go) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_RESULT;
         rsp_byte_in   = '0;
         rsp_last_in   = 1'b1;
         rsp_value_in  = reply_res.value;
         rsp_status_in = reply_res.status;
      end else if (tx_step) begin
         tx_idx_in = tx_next;
         priority if (tx_next < TX_CRC_LO_IDX) begin
            rsp_byte_in = tx_shift_ff[7:0];
            tx_shift_in = {8'h00, tx_shift_ff[39:8]};
            tx_crc_in   = crc_byte(tx_crc_ff, tx_shift_ff[7:0]);
         end else if (tx_next == TX_CRC_LO_IDX) begin
            rsp_byte_in = tx_crc_ff[7:0];
         end else begin
            rsp_byte_in = tx_crc_ff[15:8];
            rsp_last_in = 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_value_ff, rsp_byte_ff};

   `MBRM_ASSERT_IMP(a_tx_holds_output, tx_active_ff, rsp_valid_ff)
   `MBRM_ASSERT_IMP(a_no_accept_mid_frame, req_tready, !tx_active_ff || tx_idx_ff == TX_LAST_IDX)
   `MBRM_ASSERT_NEXT(a_frame_continues, rsp_take && !rsp_kind_ff && !rsp_last_ff, rsp_valid_ff && !rsp_kind_ff)
   `MBRM_ASSERT_IMP(a_result_is_last, rsp_valid_ff && rsp_kind_ff, rsp_last_ff)

endmodule

// ===== sim/modbus_rtu_read_master_top_tb.sv =====
// ---------------------------------------------------------------------------
// Modbus RTU read master: self-checking testbench
// Drives request, reply-byte and silence beats into the block and predicts
// each request frame and reply result independently. A scoreboard checks
// every result beat field by field. The run has two idling phases and one
// long receiver stall.
// ---------------------------------------------------------------------------
module modbus_rtu_read_master_top_tb;
   import mbrm_pkg::*;

   localparam int         FRAME_LIMIT = 128;
   localparam int         HALF_PERIOD = 6;
   localparam int         ITEM_GOAL   = 470;
   localparam logic [1:0] ACT_NONE    = 2'd3;
   localparam int         SPOIL_NONE  = 0;
   localparam int         SPOIL_FLIP  = 1;
   localparam int         SPOIL_CUT   = 2;

   typedef struct {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [31:0] value;
      status_type  status;
   } rsp_beat_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // slave_addr, reg_addr, reg_count, rx_byte
   logic [1:0]  req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // tx_byte, value, status, zero above
   logic        rsp_tuser;   // kind
   logic        rsp_tlast;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_len    = 0;
   int items_taken = 0;

   // bit-serial form of the reflected CRC-16
   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c  = c >> 1;
         if (fb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   class mbrm_frame_scoreboard;
      logic [15:0]  reply_crc;
      logic [7:0]   reply_len;
      logic [15:0]  reply_tail;
      logic [31:0]  reply_window;
      logic         reply_overflow;
      rsp_beat_type beats_due[$];
      int           mismatches;
      int           beats_checked;
      int           frames_sent;
      int           replies_seen[4];

      function new();
         clear_reply();
         mismatches    = 0;
         beats_checked = 0;
         frames_sent   = 0;
         foreach (replies_seen[i]) replies_seen[i] = 0;
      endfunction

      function void clear_reply();
         reply_crc      = CRC_INIT;
         reply_len      = '0;
         reply_tail     = '0;
         reply_window   = '0;
         reply_overflow = 1'b0;
      endfunction

      function void push_beat(logic kind, logic [7:0] txb, logic last, logic [31:0] value,
                              status_type st);
         rsp_beat_type b;
         b.kind    = kind;
         b.tx_byte = txb;
         b.last    = last;
         b.value   = value;
         b.status  = st;
         beats_due.push_back(b);
      endfunction

      function void take_request(logic [1:0] act, logic [47:0] data);
         logic [7:0]  frame[8];
         logic [15:0] crc;
         logic [7:0]  old;
         status_type  st;
         logic [31:0] val;
         case (act)
            ACT_SEND: begin
               frame[0] = data[7:0];
               frame[1] = FUNC_READ;
               frame[2] = data[23:16];
               frame[3] = data[15:8];
               frame[4] = data[39:32];
               frame[5] = data[31:24];
               crc = CRC_INIT;
               for (int i = 0; i < 6; i++) crc = crc16_update(crc, frame[i]);
               frame[6] = crc[7:0];
               frame[7] = crc[15:8];
               clear_reply();
               for (int i = 0; i < 8; i++) push_beat(KIND_TX, frame[i], i == 7, '0, ST_OK);
               frames_sent++;
            end
            ACT_BYTE: begin
               if (reply_len >= FRAME_LIMIT) begin
                  reply_overflow = 1'b1;
               end else begin
                  // the older tail byte leaves the trailer and joins the CRC
                  if (reply_len >= 2) begin
                     old       = reply_tail[15:8];
                     reply_crc = crc16_update(reply_crc, old);
                     if (reply_len >= 5) reply_window = {reply_window[23:0], old};
                  end
                  reply_tail = {reply_tail[7:0], data[47:40]};
                  reply_len  = reply_len + 8'd1;
               end
            end
            ACT_END: begin
               val = '0;
               if (reply_overflow) st = ST_OVERFLOW;
               else if (reply_len == 0) st = ST_NO_REPLY;
               else if (reply_len == 1) st = ST_CRC_ERR;
               else if (reply_crc[7:0] == reply_tail[15:8] &&
                        reply_crc[15:8] == reply_tail[7:0]) begin
                  st  = ST_OK;
                  val = reply_window;
               end else st = ST_CRC_ERR;
               push_beat(KIND_RESULT, '0, 1'b1, val, st);
               replies_seen[st]++;
               clear_reply();
            end
            default: ;
         endcase
      endfunction

      function void flag(string field, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s at beat %0d: expected 0x%0h, got 0x%0h",
                     field, beats_checked, want, got);
      endfunction

      function void check_beat(logic [47:0] data, logic kind, logic last);
         rsp_beat_type want;
         if (beats_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result beat 0x%0h with none expected", data);
            return;
         end
         want = beats_due.pop_front();
         beats_checked++;
         if (kind !== want.kind)           flag("kind", want.kind, kind);
         if (data[7:0] !== want.tx_byte)   flag("tx_byte", want.tx_byte, data[7:0]);
         if (last !== want.last)           flag("last", want.last, last);
         if (data[39:8] !== want.value)    flag("value", want.value, data[39:8]);
         if (data[41:40] !== want.status)  flag("status", want.status, data[41:40]);
         if (data[47:42] !== 6'd0)         flag("padding", 0, data[47:42]);
      endfunction
   endclass

   mbrm_frame_scoreboard sb;

   modbus_rtu_read_master_top #(.MAX_FRAME(FRAME_LIMIT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // note the input beat before checking, so an early result still finds its prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.take_request(req_tuser, req_tdata);
            if (req_tuser != ACT_NONE) items_taken++;
         end
         if (rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // receiver: random back-pressure plus one long hold-off
   initial begin
      int  hold_left;
      bit  hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_taken && hold_len > 0) begin
            hold_left  = hold_len;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   function automatic logic [47:0] noise48();
      return {$urandom, $urandom};
   endfunction

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic offer_beat(input logic [1:0] act, input logic [47:0] data);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = act;
      req_tdata  = data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_request(input logic [7:0] slave, input logic [15:0] ra,
                               input logic [15:0] rc);
      logic [47:0] data;
      data = noise48();
      data[39:0] = {rc, ra, slave};
      offer_beat(ACT_SEND, data);
   endtask

   task automatic random_request();
      send_request($urandom_range(255), $urandom_range(65535), $urandom_range(65535));
   endtask

   task automatic rx_byte(input logic [7:0] b);
      logic [47:0] data;
      data = noise48();
      data[47:40] = b;
      offer_beat(ACT_BYTE, data);
   endtask

   task automatic end_reply();
      offer_beat(ACT_END, noise48());
   endtask

   // well-formed reply frame, optionally spoilt by a bit flip or a cut tail
   task automatic feed_reply(input int payload_len, input int spoil);
      logic [7:0]  frame_q[$];
      logic [15:0] crc;
      int          pos;
      frame_q.push_back(8'($urandom_range(255)));
      frame_q.push_back(FUNC_READ);
      frame_q.push_back(8'(payload_len));
      repeat (payload_len) frame_q.push_back(8'($urandom_range(255)));
      crc = CRC_INIT;
      foreach (frame_q[i]) crc = crc16_update(crc, frame_q[i]);
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
      if (spoil == SPOIL_FLIP) begin
         pos = $urandom_range(frame_q.size() - 1);
         frame_q[pos] = frame_q[pos] ^ 8'(1 << $urandom_range(7));
      end else if (spoil == SPOIL_CUT) begin
         repeat ($urandom_range(1, 3)) frame_q.delete(frame_q.size() - 1);
      end
      foreach (frame_q[i]) rx_byte(frame_q[i]);
   endtask

   task automatic random_exchange();
      int pick;
      int spoil;
      int plen;
      pick = $urandom_range(99);
      if (pick < 75) begin
         random_request();
         if ($urandom_range(99) < 80) spoil = SPOIL_NONE;
         else spoil = $urandom_range(1) ? SPOIL_FLIP : SPOIL_CUT;
         plen = ($urandom_range(99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 16);
         feed_reply(plen, spoil);
         // occasionally abandon the reply with a fresh request
         if ($urandom_range(99) < 6) random_request();
         end_reply();
      end else if (pick < 85) begin
         repeat ($urandom_range(0, 6)) rx_byte($urandom_range(255));
         end_reply();
      end else if (pick < 92) begin
         repeat ($urandom_range(1, 4)) rx_byte($urandom_range(255));
         random_request();
      end else if (pick < 96) begin
         offer_beat(ACT_NONE, noise48());
      end else begin
         end_reply();
      end
   endtask

   initial begin
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = ACT_SEND;
      req_tdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes and the reply corners short of overflow
      send_request(8'h00, 16'h0000, 16'h0000);
      send_request(8'hFF, 16'hFFFF, 16'hFFFF);
      end_reply();
      rx_byte(8'h11);
      end_reply();
      rx_byte(8'hFF);
      rx_byte(8'hFF);
      end_reply();
      feed_reply(0, SPOIL_NONE);
      end_reply();
      rx_byte(8'h00);
      rx_byte(8'hFF);
      random_request();
      end_reply();
      offer_beat(ACT_NONE, noise48());

      tx_idle_pct = 10;
      rx_idle_pct = 47;
      while (items_taken < 100) random_exchange();

      tx_idle_pct = 47;
      rx_idle_pct = 10;
      while (items_taken < 200) random_exchange();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      // stall the receiver while requests keep coming, so the input backs up
      hold_len = 200;
      repeat (6) random_request();
      random_request();
      feed_reply(FRAME_LIMIT - 5, SPOIL_NONE);
      end_reply();
      random_request();
      feed_reply(FRAME_LIMIT - 4 + $urandom_range(0, 3), SPOIL_NONE);
      end_reply();
      while (items_taken < ITEM_GOAL) random_exchange();

      req_tvalid = 1'b0;
      while (sb.beats_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d input beats, %0d request frames, %0d result beats checked",
               items_taken, sb.frames_sent, sb.beats_checked);
      $display("reply results: ok %0d, no reply %0d, crc error %0d, overflow %0d",
               sb.replies_seen[ST_OK], sb.replies_seen[ST_NO_REPLY],
               sb.replies_seen[ST_CRC_ERR], sb.replies_seen[ST_OVERFLOW]);
      if (sb.mismatches == 0 && sb.beats_due.size() == 0) begin
         $display("modbus_rtu_read_master_top_tb passed");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("modbus_rtu_read_master_top_tb failed");
      end
      $finish;
   end

   initial begin
      #(2 * HALF_PERIOD * 400000);
      $display("timed out with %0d result beats outstanding", sb.beats_due.size());
      $display("modbus_rtu_read_master_top_tb failed");
      $finish;
   end

endmodule
